// ===== hdl/oriented_box_to_aligned_bounds_unit_macros.svh =====
// Assertion macros for the checker file of the bounds unit.
`ifndef ORIENTED_BOX_TO_ALIGNED_BOUNDS_UNIT_MACROS_SVH
`define ORIENTED_BOX_TO_ALIGNED_BOUNDS_UNIT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define OBB_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("obb check failed: condition does not hold");

// A condition that must be followed, a fixed number of cycles later, by another.
`define OBB_ASSERT_AFTER(lbl, clk, rst_n, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("obb check failed: expected response missing");

`endif

// ===== hdl/obb_pkg.sv =====
`timescale 1ns / 1ps

package obb_pkg;

    localparam int COORD_W    = 32;
    localparam int EXT_W      = 31;
    localparam int QUAT_W     = 16;
    localparam int PROD_W     = 2 * QUAT_W;
    localparam int MAT_W      = PROD_W + 2;
    localparam int MAG_W      = PROD_W + 1;
    localparam int TERM_W     = PROD_W + EXT_W;
    localparam int SUM_W      = TERM_W + 2;
    localparam int FRAC_SHIFT = 28;
    localparam int HALF_W     = SUM_W - FRAC_SHIFT;
    localparam int BOUND_W    = HALF_W + 2;
    localparam int LATENCY    = 5;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic        [EXT_W-1:0]   half_extent_x;
        logic        [EXT_W-1:0]   half_extent_y;
        logic        [EXT_W-1:0]   half_extent_z;
        logic signed [QUAT_W-1:0]  quat_i;
        logic signed [QUAT_W-1:0]  quat_j;
        logic signed [QUAT_W-1:0]  quat_k;
        logic signed [QUAT_W-1:0]  quat_real;
    } obb_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] lower_x;
        logic signed [COORD_W-1:0] lower_y;
        logic signed [COORD_W-1:0] lower_z;
        logic signed [COORD_W-1:0] upper_x;
        logic signed [COORD_W-1:0] upper_y;
        logic signed [COORD_W-1:0] upper_z;
    } obb_out_t;

    // Per-axis vectors; index 0 is x, 1 is y, 2 is z.
    typedef logic signed [2:0][COORD_W-1:0] obb_center_t;
    typedef logic        [2:0][EXT_W-1:0]   obb_extent_t;
    typedef logic        [2:0][2:0][MAG_W-1:0]  obb_mag_t;
    typedef logic        [2:0][2:0][TERM_W-1:0] obb_term_t;
    typedef logic        [2:0][HALF_W-1:0]  obb_width_t;

endpackage

// ===== hdl/obb_rot_matrix.sv =====
`timescale 1ns / 1ps

module obb_rot_matrix (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  obb_pkg::obb_in_t     box,
    output logic                 out_valid,
    output obb_pkg::obb_center_t center,
    output obb_pkg::obb_extent_t extent,
    output obb_pkg::obb_mag_t    mag
);
    import obb_pkg::*;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [MAT_W-1:0]  mat_t;

    function automatic prod_t smul(input logic signed [QUAT_W-1:0] a,
                                   input logic signed [QUAT_W-1:0] b);
        smul = PROD_W'(a) * PROD_W'(b);
    endfunction

    function automatic mat_t wide(input prod_t p);
        wide = MAT_W'(p);
    endfunction

    function automatic logic [MAG_W-1:0] absval(input mat_t m);
        mat_t n;
        n = m[MAT_W-1] ? -m : m;
        absval = n[MAG_W-1:0];
    endfunction

    // Stage one: the ten quadratic terms of the quaternion.
    prod_t ii_reg, jj_reg, kk_reg, rr_reg, ij_reg, ik_reg, jk_reg, ri_reg, rj_reg, rk_reg;
    prod_t ii_next, jj_next, kk_next, rr_next, ij_next, ik_next, jk_next;
    prod_t ri_next, rj_next, rk_next;
    obb_center_t s1_center_reg;
    obb_extent_t s1_extent_reg;
    logic        s1_valid_reg;

    // Stage two: magnitudes of the rotation matrix entries.
    obb_mag_t    mag_reg, mag_next;
    obb_center_t s2_center_reg;
    obb_extent_t s2_extent_reg;
    logic        s2_valid_reg;

    mat_t [2:0][2:0] mat;

    always_comb
    begin
        ii_next = smul(box.quat_i, box.quat_i);
        jj_next = smul(box.quat_j, box.quat_j);
        kk_next = smul(box.quat_k, box.quat_k);
        rr_next = smul(box.quat_real, box.quat_real);
        ij_next = smul(box.quat_i, box.quat_j);
        ik_next = smul(box.quat_i, box.quat_k);
        jk_next = smul(box.quat_j, box.quat_k);
        ri_next = smul(box.quat_real, box.quat_i);
        rj_next = smul(box.quat_real, box.quat_j);
        rk_next = smul(box.quat_real, box.quat_k);
    end

    always_comb
    begin
        mat[0][0] = wide(rr_reg) + wide(ii_reg) - wide(jj_reg) - wide(kk_reg);
        mat[0][1] = (wide(ij_reg) - wide(rk_reg)) <<< 1;
        mat[0][2] = (wide(ik_reg) + wide(rj_reg)) <<< 1;
        mat[1][0] = (wide(ij_reg) + wide(rk_reg)) <<< 1;
        mat[1][1] = wide(rr_reg) - wide(ii_reg) + wide(jj_reg) - wide(kk_reg);
        mat[1][2] = (wide(jk_reg) - wide(ri_reg)) <<< 1;
        mat[2][0] = (wide(ik_reg) - wide(rj_reg)) <<< 1;
        mat[2][1] = (wide(jk_reg) + wide(ri_reg)) <<< 1;
        mat[2][2] = wide(rr_reg) - wide(ii_reg) - wide(jj_reg) + wide(kk_reg);
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                mag_next[a][b] = absval(mat[a][b]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ii_reg <= ii_next;
        jj_reg <= jj_next;
        kk_reg <= kk_next;
        rr_reg <= rr_next;
        ij_reg <= ij_next;
        ik_reg <= ik_next;
        jk_reg <= jk_next;
        ri_reg <= ri_next;
        rj_reg <= rj_next;
        rk_reg <= rk_next;
        s1_center_reg <= {box.center_z, box.center_y, box.center_x};
        s1_extent_reg <= {box.half_extent_z, box.half_extent_y, box.half_extent_x};
        mag_reg       <= mag_next;
        s2_center_reg <= s1_center_reg;
        s2_extent_reg <= s1_extent_reg;
    end

    assign out_valid = s2_valid_reg;
    assign center    = s2_center_reg;
    assign extent    = s2_extent_reg;
    assign mag       = mag_reg;

endmodule

// ===== hdl/obb_axis_scale.sv =====
`timescale 1ns / 1ps

module obb_axis_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  obb_pkg::obb_center_t center_in,
    input  obb_pkg::obb_extent_t extent,
    input  obb_pkg::obb_mag_t    mag,
    output logic                 out_valid,
    output obb_pkg::obb_center_t center_out,
    output obb_pkg::obb_term_t   term
);
    import obb_pkg::*;

    localparam int LOW_W = MAG_W - 1;

    obb_term_t   term_reg, term_next;
    obb_center_t center_reg;
    logic        valid_reg;

    // An entry reaches its top bit only at exactly one full unit of that
    // bit, so that case is a shift of the extent and the multiplier stays
    // at the width of the lower bits.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                if (mag[a][b][MAG_W-1])
                begin
                    term_next[a][b] = TERM_W'({extent[b], {LOW_W{1'b0}}});
                end
                else
                begin
                    term_next[a][b] = TERM_W'(mag[a][b][LOW_W-1:0]) * TERM_W'(extent[b]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg   <= term_next;
        center_reg <= center_in;
    end

    assign out_valid  = valid_reg;
    assign center_out = center_reg;
    assign term       = term_reg;

endmodule

// ===== hdl/obb_bound_sat.sv =====
`timescale 1ns / 1ps

module obb_bound_sat (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  obb_pkg::obb_center_t center,
    input  obb_pkg::obb_term_t   term,
    output logic                 out_valid,
    output obb_pkg::obb_out_t    bounds
);
    import obb_pkg::*;

    localparam logic [SUM_W-1:0] HALF_UNIT = SUM_W'(1) << (FRAC_SHIFT - 1);

    typedef logic signed [BOUND_W-1:0] bound_t;

    function automatic logic signed [COORD_W-1:0] sat(input bound_t v);
        bound_t hi;
        bound_t lo;
        hi = BOUND_W'({1'b0, {(COORD_W-1){1'b1}}});
        lo = -hi - BOUND_W'(1);
        if (v > hi)
        begin
            sat = hi[COORD_W-1:0];
        end
        else if (v < lo)
        begin
            sat = lo[COORD_W-1:0];
        end
        else
        begin
            sat = v[COORD_W-1:0];
        end
    endfunction

    // Stage four: rounded half width per axis.
    obb_width_t        width_reg, width_next;
    obb_center_t       center_reg;
    logic              s4_valid_reg;
    logic [SUM_W-1:0]  sum [3];

    // Stage five: saturated bounds.
    obb_out_t          bounds_reg, bounds_next;
    logic              s5_valid_reg;
    bound_t            lower [3];
    bound_t            upper [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sum[a] = SUM_W'(term[a][0]) + SUM_W'(term[a][1]) + SUM_W'(term[a][2]) + HALF_UNIT;
            width_next[a] = sum[a][SUM_W-1:FRAC_SHIFT];
        end
    end

    // The elements of the packed center vector are unsigned, so each one is
    // reinterpreted as signed before it is widened.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            lower[a] = BOUND_W'($signed(center_reg[a])) - bound_t'({2'b00, width_reg[a]});
            upper[a] = BOUND_W'($signed(center_reg[a])) + bound_t'({2'b00, width_reg[a]});
        end
        bounds_next.lower_x = sat(lower[0]);
        bounds_next.lower_y = sat(lower[1]);
        bounds_next.lower_z = sat(lower[2]);
        bounds_next.upper_x = sat(upper[0]);
        bounds_next.upper_y = sat(upper[1]);
        bounds_next.upper_z = sat(upper[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= in_valid;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg  <= width_next;
        center_reg <= center;
        bounds_reg <= bounds_next;
    end

    assign out_valid = s5_valid_reg;
    assign bounds    = bounds_reg;

endmodule

// ===== hdl/oriented_box_to_aligned_bounds_unit.sv =====
`timescale 1ns / 1ps
//  Channel   Signals              Direction  Transfer
//  box       start, busy, box     in         start high and busy low at a rising edge
//  bounds    done, bounds         out        done high for one cycle, taken at its end
//
//  One box can enter in every cycle that start is high; busy is always low. The bounds of a box
//  accepted at one edge are on the bounds port, with done high, once it has passed
//  through every register stage of the chain below.
//  The depth is set by the chain quaternion products, matrix entries,
//  extent multipliers, rounded sum and saturating add, one register stage each.
//  Reset clears only the stage valid bits; no box is in flight afterwards.
//  The receiver cannot stall, so the pipeline never holds.

module oriented_box_to_aligned_bounds_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  obb_pkg::obb_in_t  box,
    output logic              done,
    output obb_pkg::obb_out_t bounds
);
    import obb_pkg::*;

    // The box is accepted whenever start is high; nothing downstream pushes back.
    logic        accept;

    logic        rot_valid;
    obb_center_t rot_center;
    obb_extent_t rot_extent;
    obb_mag_t    rot_mag;

    logic        scale_valid;
    obb_center_t scale_center;
    obb_term_t   scale_term;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Stages one and two: quaternion squares and cross terms, then the
    // magnitude of every rotation matrix entry.
    obb_rot_matrix u_rot_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .box       (box),
        .out_valid (rot_valid),
        .center    (rot_center),
        .extent    (rot_extent),
        .mag       (rot_mag)
    );

    // Stage three: each matrix magnitude scaled by the matching half extent.
    obb_axis_scale u_axis_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rot_valid),
        .center_in  (rot_center),
        .extent     (rot_extent),
        .mag        (rot_mag),
        .out_valid  (scale_valid),
        .center_out (scale_center),
        .term       (scale_term)
    );

    // Stages four and five: the rounded half width per axis, then the
    // center minus and plus that width, saturated to 32 bits.
    obb_bound_sat u_bound_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .center    (scale_center),
        .term      (scale_term),
        .out_valid (done),
        .bounds    (bounds)
    );

endmodule

// ===== hdl/obb_checker.sv =====
`timescale 1ns / 1ps
`include "oriented_box_to_aligned_bounds_unit_macros.svh"

module obb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input obb_pkg::obb_in_t  box,
    input logic              done,
    input obb_pkg::obb_out_t bounds
);
    import obb_pkg::*;

    logic zero_quat;

    assign zero_quat = (box.quat_i == '0) && (box.quat_j == '0) &&
                       (box.quat_k == '0) && (box.quat_real == '0);

    `OBB_ASSERT_ALWAYS(never_busy, clk, rst_n, !busy)

    `OBB_ASSERT_AFTER(result_follows_transfer, clk, rst_n, start && !busy, 5, done)

    `OBB_ASSERT_ALWAYS(bounds_ordered, clk, rst_n, !done || ((bounds.lower_x <= bounds.upper_x) && (bounds.lower_y <= bounds.upper_y) && (bounds.lower_z <= bounds.upper_z)))

    `OBB_ASSERT_AFTER(zero_quat_gives_center, clk, rst_n, start && !busy && zero_quat, 5, (bounds.lower_x == $past(box.center_x, 5)) && (bounds.upper_z == $past(box.center_z, 5)))

endmodule

bind oriented_box_to_aligned_bounds_unit obb_checker u_obb_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .box    (box),
    .done   (done),
    .bounds (bounds)
);

// ===== tb/oriented_box_to_aligned_bounds_unit_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the oriented box to axis-aligned bounds unit.
// Boxes are queued up front by the stimulus block. A clocked driver hands them to the
// unit one transfer at a time, with random gaps. A clocked monitor compares every
// bounds result against the oldest prediction still waiting.
module oriented_box_to_aligned_bounds_unit_test;

    import obb_pkg::*;

    // Wide enough to hold every intermediate of the bounds arithmetic exactly:
    // products of a matrix magnitude (up to 2^32) and an extent (below 2^31),
    // the sum of three of them, and the center plus or minus the half width.
    typedef logic signed [69:0] wide_t;

    localparam int     RANDOM_BOXES = 550;
    localparam int     CYCLE_LIMIT  = 200000;
    localparam wide_t  SAT_HIGH     = 70'sd2147483647;
    localparam wide_t  SAT_LOW      = -70'sd2147483648;
    localparam wide_t  ROUND_HALF   = 70'sd134217728;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    obb_in_t  box = '0;
    logic     done;
    obb_out_t bounds;

    obb_in_t  pending_boxes[$];
    obb_out_t expected_bounds[$];
    int       boxes_sent = 0;
    int       total_boxes = 0;
    int       bounds_errors = 0;
    int       cycle_count = 0;

    oriented_box_to_aligned_bounds_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .box    (box),
        .done   (done),
        .bounds (bounds)
    );

    always #2 clk = ~clk;

    // Clamp an exact bound to the signed 32-bit range of the output fields.
    function automatic logic [31:0] saturate_bound(wide_t v);
        if (v > SAT_HIGH)
            return 32'h7FFF_FFFF;
        if (v < SAT_LOW)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // The rotation is linear, so the extreme corner along each axis is reached by
    // summing |M_ab| * e_b over the local axes. The entries of M are exact in units
    // of 2^-28, and the half width is rounded half up to units of 2^-16.
    function automatic obb_out_t predict_bounds(obb_in_t b);
        wide_t       qi, qj, qk, qr;
        wide_t       ii, jj, kk, rr, ij, ik, jk, ri, rj, rk;
        wide_t       rot[3][3];
        wide_t       ext[3];
        wide_t       ctr[3];
        wide_t       acc, mag_v, half_w;
        logic [31:0] lo_f[3];
        logic [31:0] hi_f[3];
        obb_out_t    r;
        int          a, c;

        qi = $signed(b.quat_i);
        qj = $signed(b.quat_j);
        qk = $signed(b.quat_k);
        qr = $signed(b.quat_real);
        ctr[0] = $signed(b.center_x);
        ctr[1] = $signed(b.center_y);
        ctr[2] = $signed(b.center_z);
        ext[0] = b.half_extent_x;
        ext[1] = b.half_extent_y;
        ext[2] = b.half_extent_z;

        ii = qi * qi; jj = qj * qj; kk = qk * qk; rr = qr * qr;
        ij = qi * qj; ik = qi * qk; jk = qj * qk;
        ri = qr * qi; rj = qr * qj; rk = qr * qk;

        rot[0][0] = rr + ii - jj - kk;
        rot[0][1] = 2 * (ij - rk);
        rot[0][2] = 2 * (ik + rj);
        rot[1][0] = 2 * (ij + rk);
        rot[1][1] = rr - ii + jj - kk;
        rot[1][2] = 2 * (jk - ri);
        rot[2][0] = 2 * (ik - rj);
        rot[2][1] = 2 * (jk + ri);
        rot[2][2] = rr - ii - jj + kk;

        for (a = 0; a < 3; a++)
        begin
            acc = ROUND_HALF;
            for (c = 0; c < 3; c++)
            begin
                mag_v = (rot[a][c] < 0) ? -rot[a][c] : rot[a][c];
                acc = acc + mag_v * ext[c];
            end
            half_w  = acc >>> 28;
            lo_f[a] = saturate_bound(ctr[a] - half_w);
            hi_f[a] = saturate_bound(ctr[a] + half_w);
        end

        r.lower_x = lo_f[0];
        r.lower_y = lo_f[1];
        r.lower_z = lo_f[2];
        r.upper_x = hi_f[0];
        r.upper_y = hi_f[1];
        r.upper_z = hi_f[2];
        return r;
    endfunction

    function automatic obb_in_t make_box(
        logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
        logic [30:0] ex, logic [30:0] ey, logic [30:0] ez,
        logic [15:0] qi, logic [15:0] qj, logic [15:0] qk, logic [15:0] qr
    );
        obb_in_t b;
        b.center_x      = cx;
        b.center_y      = cy;
        b.center_z      = cz;
        b.half_extent_x = ex;
        b.half_extent_y = ey;
        b.half_extent_z = ez;
        b.quat_i        = qi;
        b.quat_j        = qj;
        b.quat_k        = qk;
        b.quat_real     = qr;
        return b;
    endfunction

    // Random boxes. Most carry a near-unit orientation, the way real scenes do.
    // The rest use raw 16-bit components, which reach non-unit and saturating cases
    // and toggle every quaternion bit. Sizes are mostly modest, with some at full
    // width so that the upper extent and center bits are exercised too.
    function automatic obb_in_t make_random_box();
        obb_in_t     b;
        real         qa, qb, qc, qd, norm;
        int          mode;
        logic [31:0] ctr[3];
        logic [30:0] ext[3];
        int          a;

        for (a = 0; a < 3; a++)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 6)
                ctr[a] = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            else
                ctr[a] = $urandom;
            mode = $urandom_range(0, 9);
            if (mode < 4)
                ext[a] = 31'($urandom_range(0, 32'h000F_FFFF));
            else if (mode < 7)
                ext[a] = 31'($urandom_range(0, 32'h00FF_FFFF));
            else
                ext[a] = 31'($urandom);
        end
        b = make_box(ctr[0], ctr[1], ctr[2], ext[0], ext[1], ext[2],
                     16'h0000, 16'h0000, 16'h0000, 16'h0000);

        mode = $urandom_range(0, 9);
        if (mode < 7)
        begin
            qa = $itor($urandom_range(0, 2000)) - 1000.0;
            qb = $itor($urandom_range(0, 2000)) - 1000.0;
            qc = $itor($urandom_range(0, 2000)) - 1000.0;
            qd = $itor($urandom_range(0, 2000)) - 1000.0;
            norm = $sqrt(qa * qa + qb * qb + qc * qc + qd * qd);
            if (norm == 0.0)
            begin
                qd = 1.0;
                norm = 1.0;
            end
            b.quat_i    = 16'($rtoi(qa / norm * 16384.0));
            b.quat_j    = 16'($rtoi(qb / norm * 16384.0));
            b.quat_k    = 16'($rtoi(qc / norm * 16384.0));
            b.quat_real = 16'($rtoi(qd / norm * 16384.0));
        end
        else
        begin
            b.quat_i    = 16'($urandom);
            b.quat_j    = 16'($urandom);
            b.quat_k    = 16'($urandom);
            b.quat_real = 16'($urandom);
        end
        return b;
    endfunction

    task automatic report_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            bounds_errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, exp_v, act_v);
        end
    endtask

    // Driver. A transfer happens at an edge where start is high and busy is low.
    // The box on the port is always the head of the pending queue, and it is
    // popped only once its transfer is seen. While a box waits for busy to drop,
    // start and box are left alone. Otherwise the next box is offered unless this
    // cycle is chosen as a gap. The gap rate follows the run's three phases:
    // sparse gaps, dense gaps, then none at all.
    always @(posedge clk)
    begin
        int  idle_pct;
        bit  taken;

        if (rst_n)
        begin
            taken = start && !busy;
            if (taken)
            begin
                expected_bounds.push_back(predict_bounds(box));
                void'(pending_boxes.pop_front());
                boxes_sent++;
            end
            if (boxes_sent < total_boxes / 3)
                idle_pct = 14;
            else if (boxes_sent < (2 * total_boxes) / 3)
                idle_pct = 71;
            else
                idle_pct = 0;
            if (!start || taken)
            begin
                if (pending_boxes.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    start <= 1'b1;
                    box   <= pending_boxes[0];
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every done pulse is a transfer that cannot be held off, so it is
    // checked in the cycle it appears.
    always @(posedge clk)
    begin
        obb_out_t want;

        if (rst_n && done)
        begin
            if (expected_bounds.size() == 0)
            begin
                bounds_errors++;
                $display("%0t ns: unexpected bounds transfer, expected none, actual %h",
                         $time, bounds);
            end
            else
            begin
                want = expected_bounds.pop_front();
                report_field("lower_x", want.lower_x, bounds.lower_x);
                report_field("lower_y", want.lower_y, bounds.lower_y);
                report_field("lower_z", want.lower_z, bounds.lower_z);
                report_field("upper_x", want.upper_x, bounds.upper_x);
                report_field("upper_y", want.upper_y, bounds.upper_y);
                report_field("upper_z", want.upper_z, bounds.upper_z);
            end
        end
    end

    // Watchdog. A correct run ends long before CYCLE_LIMIT, so a run that
    // gets this far has stopped producing results.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("oriented_box_to_aligned_bounds_unit_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        int n;

        // Directed boxes first. An empty box with a zero quaternion comes first.
        pending_boxes.push_back(make_box(32'h0, 32'h0, 32'h0, 31'h0, 31'h0, 31'h0,
                                         16'h0, 16'h0, 16'h0, 16'h0));
        // Identity orientation: the bounds are just center plus or minus extents.
        pending_boxes.push_back(make_box(32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000,
                                         31'h0002_0000, 31'h0000_4000, 31'h0010_0000,
                                         16'h0, 16'h0, 16'h0, 16'h4000));
        // Identity with a negated real part describes the same rotation.
        pending_boxes.push_back(make_box(32'h1234_5678, 32'h8765_4321, 32'h0,
                                         31'h0003_0000, 31'h0005_0000, 31'h0007_0000,
                                         16'h0, 16'h0, 16'h0, 16'hC000));
        // A zero quaternion with the largest extents collapses onto the center.
        pending_boxes.push_back(make_box(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                         31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                         16'h0, 16'h0, 16'h0, 16'h0));
        // Quarter turns about each axis swap extents between axes.
        pending_boxes.push_back(make_box(32'h0, 32'h0, 32'h0,
                                         31'h0001_0000, 31'h0002_0000, 31'h0004_0000,
                                         16'h2D41, 16'h0, 16'h0, 16'h2D41));
        pending_boxes.push_back(make_box(32'h0, 32'h0, 32'h0,
                                         31'h0001_0000, 31'h0002_0000, 31'h0004_0000,
                                         16'h0, 16'h2D41, 16'h0, 16'h2D41));
        pending_boxes.push_back(make_box(32'h0, 32'h0, 32'h0,
                                         31'h0001_0000, 31'h0002_0000, 31'h0004_0000,
                                         16'h0, 16'h0, 16'hD2BF, 16'h2D41));
        // Half turns with pure vector quaternions.
        pending_boxes.push_back(make_box(32'h0010_0000, 32'h0020_0000, 32'h0030_0000,
                                         31'h0000_1234, 31'h0000_5678, 31'h0000_9ABC,
                                         16'h4000, 16'h0, 16'h0, 16'h0));
        pending_boxes.push_back(make_box(32'h0010_0000, 32'h0020_0000, 32'h0030_0000,
                                         31'h0000_1234, 31'h0000_5678, 31'h0000_9ABC,
                                         16'h0, 16'hC000, 16'h0, 16'h0));
        // A general unit orientation of equal components.
        pending_boxes.push_back(make_box(32'hFFF0_0000, 32'h000F_0000, 32'h0,
                                         31'h0001_8000, 31'h0000_0001, 31'h0040_0000,
                                         16'h2000, 16'h2000, 16'h2000, 16'h2000));
        // A quaternion that is not of unit length scales the box by its square norm.
        pending_boxes.push_back(make_box(32'h0, 32'h0, 32'h0,
                                         31'h0001_0000, 31'h0001_0000, 31'h0001_0000,
                                         16'h0, 16'h0, 16'h0, 16'h7FFF));
        pending_boxes.push_back(make_box(32'h0, 32'h0, 32'h0,
                                         31'h0001_0000, 31'h0001_0000, 31'h0001_0000,
                                         16'h0, 16'h0, 16'h0, 16'h2000));
        // Most negative components with the largest extents saturate both bounds.
        pending_boxes.push_back(make_box(32'h0, 32'h0, 32'h0,
                                         31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                         16'h8000, 16'h8000, 16'h8000, 16'h8000));
        pending_boxes.push_back(make_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                         31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                         16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        // Extreme centers with small boxes: one side saturates, the other does not.
        pending_boxes.push_back(make_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_0000,
                                         31'h0000_0001, 31'h0000_0001, 31'h0002_0000,
                                         16'h0, 16'h0, 16'h0, 16'h4000));
        pending_boxes.push_back(make_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_FFFF,
                                         31'h0000_0001, 31'h0000_0001, 31'h0002_0000,
                                         16'h0, 16'h0, 16'h0, 16'h4000));
        // All input bits set: every quaternion component is minus one least significant bit.
        pending_boxes.push_back(make_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                         16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // Tiny extents and tiny quaternions exercise the rounding to 2^-16.
        pending_boxes.push_back(make_box(32'h0, 32'h0, 32'h0,
                                         31'h0000_0001, 31'h0000_0003, 31'h0000_0007,
                                         16'h0001, 16'h0002, 16'h0003, 16'h3FFF));
        pending_boxes.push_back(make_box(32'h0, 32'h0, 32'h0,
                                         31'h0000_8000, 31'h0000_8000, 31'h0000_8000,
                                         16'h0001, 16'h0001, 16'h0001, 16'h0001));
        pending_boxes.push_back(make_box(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333,
                                         31'h2AAA_AAAA, 31'h5555_5555, 31'h0F0F_0F0F,
                                         16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC));

        for (n = 0; n < RANDOM_BOXES; n++)
            pending_boxes.push_back(make_random_box());
        total_boxes = pending_boxes.size();

        // Reset once, then let the driver run.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every box must have been taken and every prediction met.
        while (pending_boxes.size() > 0 || expected_bounds.size() > 0)
            @(posedge clk);
        repeat (4 * LATENCY) @(posedge clk);

        if (bounds_errors == 0 && expected_bounds.size() == 0)
            $display("oriented_box_to_aligned_bounds_unit_test OK");
        else
            $display("oriented_box_to_aligned_bounds_unit_test NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/obb_pkg.sv
hdl/obb_rot_matrix.sv
hdl/obb_axis_scale.sv
hdl/obb_bound_sat.sv
hdl/oriented_box_to_aligned_bounds_unit.sv
hdl/obb_checker.sv
tb/oriented_box_to_aligned_bounds_unit_test.sv
